@@ hdl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold whenever the antecedent holds.
`define ASSERT_IMPL(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

// Condition must never be seen.
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ hdl/bpt_pkg.sv @@
// Shared types, widths and helpers for the barycentric point-in-triangle block.
// Depends on nothing.
package bpt_pkg;

  localparam int COORD_BITS       = 32;
  localparam int WEIGHT_FRAC_BITS = 24;
  localparam int Q_W              = 32;
  localparam int THR_W            = 25;
  localparam int PROD_W           = 2 * COORD_BITS;
  localparam int MINOR_W          = PROD_W + 2;
  localparam int LO_W             = COORD_BITS;
  localparam int HI_W             = MINOR_W - LO_W;
  localparam int PH_W             = HI_W + COORD_BITS;
  localparam int PL_W             = LO_W + 1 + COORD_BITS;
  localparam int DET_W            = 3 * COORD_BITS + 2;
  localparam int MAG_W            = DET_W - 1;
  localparam int REM_W            = MAG_W + Q_W + 1;
  localparam int DET_LAT          = 5;
  localparam int DIV_LAT          = Q_W + 1;
  localparam int RESULT_LAT       = DET_LAT + Q_W + 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    mag_t           den_mag;
    mag_t [2:0]     num_mag;
    logic [2:0]     num_neg;
    logic           degen;
  } item_t;

  // Clamp the raw quotient to the signed range, apply the dead zone, restore the sign.
  function automatic logic [Q_W-1:0] fix_weight(input logic [Q_W-1:0] q, input logic sat,
                                                input logic neg, input logic [THR_W-1:0] thr);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] mag;
    lim = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    mag = (sat || (q > lim)) ? lim : q;
    if (mag < Q_W'(thr)) mag = '0;
    return neg ? (~mag + 1'b1) : mag;
  endfunction

endpackage

@@ hdl/bpt_det.sv @@
// Pipelined exact 3x3 determinant of rows r0, r1, r2.
// Depends on bpt_pkg.
module bpt_det (
  input  logic                               clk_i,
  input  bpt_pkg::vec_t                      r0_i,
  input  bpt_pkg::vec_t                      r1_i,
  input  bpt_pkg::vec_t                      r2_i,
  output logic signed [bpt_pkg::DET_W-1:0]   det_o
);
  import bpt_pkg::*;

  logic signed [PROD_W-1:0]  prod_d [6];
  logic signed [PROD_W-1:0]  prod_q [6];
  logic signed [MINOR_W-1:0] minor_d [3];
  logic signed [MINOR_W-1:0] minor_q [3];
  logic signed [PH_W-1:0]    phi_d [3];
  logic signed [PH_W-1:0]    phi_q [3];
  logic signed [PL_W-1:0]    plo_d [3];
  logic signed [PL_W-1:0]    plo_q [3];
  logic signed [DET_W-1:0]   term_d [3];
  logic signed [DET_W-1:0]   term_q [3];
  logic signed [DET_W-1:0]   det_q;
  vec_t                      r0_q1, r0_q2;
  coord_t                    col [3];
  logic signed [HI_W-1:0]    hi [3];
  logic signed [LO_W:0]      lo [3];

  always_comb begin
    prod_d[0] = PROD_W'(r1_i.y) * PROD_W'(r2_i.z);
    prod_d[1] = PROD_W'(r1_i.z) * PROD_W'(r2_i.y);
    prod_d[2] = PROD_W'(r1_i.x) * PROD_W'(r2_i.z);
    prod_d[3] = PROD_W'(r1_i.z) * PROD_W'(r2_i.x);
    prod_d[4] = PROD_W'(r1_i.x) * PROD_W'(r2_i.y);
    prod_d[5] = PROD_W'(r1_i.y) * PROD_W'(r2_i.x);
    col[0] = r0_q2.x;
    col[1] = r0_q2.y;
    col[2] = r0_q2.z;
    for (int k = 0; k < 3; k++) begin
      minor_d[k] = MINOR_W'(prod_q[2*k]) - MINOR_W'(prod_q[2*k+1]);
      // Split the minor so each partial product stays near 32 by 32 bits.
      hi[k]      = minor_q[k][MINOR_W-1:LO_W];
      lo[k]      = {1'b0, minor_q[k][LO_W-1:0]};
      phi_d[k]   = PH_W'(hi[k]) * PH_W'(col[k]);
      plo_d[k]   = PL_W'(lo[k]) * PL_W'(col[k]);
      term_d[k]  = (DET_W'(phi_q[k]) <<< LO_W) + DET_W'(plo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    minor_q <= minor_d;
    phi_q   <= phi_d;
    plo_q   <= plo_d;
    term_q  <= term_d;
    det_q   <= term_q[0] - term_q[1] + term_q[2];
    r0_q1   <= r0_i;
    r0_q2   <= r0_q1;
  end

  assign det_o = det_q;

endmodule

@@ hdl/bpt_front.sv @@
// Front end: captures a request, forms the four determinants, classifies the triangle.
// Depends on bpt_pkg and bpt_det.
module bpt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  bpt_pkg::vec_t    vert_a_i,
  input  bpt_pkg::vec_t    vert_b_i,
  input  bpt_pkg::vec_t    vert_c_i,
  input  bpt_pkg::vec_t    point_i,
  output logic             push_o,
  output bpt_pkg::item_t   item_o
);
  import bpt_pkg::*;

  vec_t                    a_q, b_q, c_q, p_q;
  logic [DET_LAT:0]        vld_q;
  logic signed [DET_W-1:0] den, num [3];
  logic                    den_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DET_LAT-1:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_q <= vert_a_i;
      b_q <= vert_b_i;
      c_q <= vert_c_i;
      p_q <= point_i;
    end
  end

  bpt_det u_den (.clk_i, .r0_i(a_q), .r1_i(b_q), .r2_i(c_q), .det_o(den));
  bpt_det u_na  (.clk_i, .r0_i(p_q), .r1_i(b_q), .r2_i(c_q), .det_o(num[0]));
  bpt_det u_nb  (.clk_i, .r0_i(a_q), .r1_i(p_q), .r2_i(c_q), .det_o(num[1]));
  bpt_det u_nc  (.clk_i, .r0_i(a_q), .r1_i(b_q), .r2_i(p_q), .det_o(num[2]));

  always_comb begin
    den_neg        = den[DET_W-1];
    item_o.degen   = (den == '0);
    item_o.den_mag = den_neg ? mag_t'(-den) : mag_t'(den);
    for (int k = 0; k < 3; k++) begin
      item_o.num_mag[k] = num[k][DET_W-1] ? mag_t'(-num[k]) : mag_t'(num[k]);
      item_o.num_neg[k] = num[k][DET_W-1] ^ den_neg;
    end
  end

  assign push_o = vld_q[DET_LAT];

endmodule

@@ hdl/bpt_fifo.sv @@
// Two-entry queue between the determinant front end and the divider back end.
// Depends on bpt_pkg.
module bpt_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bpt_pkg::item_t   wdata_i,
  input  logic             pop_i,
  output bpt_pkg::item_t   rdata_o,
  output logic             empty_o,
  output logic             full_o
);
  import bpt_pkg::*;

  item_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

@@ hdl/bpt_div.sv @@
// Pipelined restoring divider: quotient of num * 2^WEIGHT_FRAC_BITS by den, one bit a stage.
// Depends on bpt_pkg.
module bpt_div (
  input  logic                  clk_i,
  input  bpt_pkg::mag_t         num_i,
  input  bpt_pkg::mag_t         den_i,
  output logic [bpt_pkg::Q_W-1:0] quo_o,
  output logic                  sat_o
);
  import bpt_pkg::*;

  logic [REM_W-1:0] rem_q [Q_W+1];
  mag_t             den_q [Q_W+1];
  logic [Q_W-1:0]   quo_q [Q_W+1];
  logic             sat_q [Q_W+1];

  // The quotient overflows 32 bits exactly when the scaled numerator reaches den * 2^32.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= REM_W'(num_i) << WEIGHT_FRAC_BITS;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    sat_q[0] <= ((REM_W'(num_i) << WEIGHT_FRAC_BITS) >= (REM_W'(den_i) << Q_W));
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;
    assign trial = REM_W'(den_q[k-1]) << (Q_W - k);
    assign ge    = (rem_q[k-1] >= trial);
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? (rem_q[k-1] - trial) : rem_q[k-1];
      den_q[k] <= den_q[k-1];
      quo_q[k] <= {quo_q[k-1][Q_W-2:0], ge};
      sat_q[k] <= sat_q[k-1];
    end
  end

  assign quo_o = quo_q[Q_W];
  assign sat_o = sat_q[Q_W];

endmodule

@@ hdl/bpt_back.sv @@
// Back end: three dividers, saturation, dead zone and the inside test.
// Depends on bpt_pkg and bpt_div.
module bpt_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bpt_pkg::THR_W-1:0] thr_i,
  input  logic                     valid_i,
  input  bpt_pkg::item_t           item_i,
  output logic                     done_o,
  output logic [bpt_pkg::Q_W-1:0]  weight_a_o,
  output logic [bpt_pkg::Q_W-1:0]  weight_b_o,
  output logic [bpt_pkg::Q_W-1:0]  weight_c_o,
  output logic                     inside_res_o,
  output logic                     degenerate_o
);
  import bpt_pkg::*;

  logic [DIV_LAT-1:0] vld_q;
  logic [2:0]         neg_q [DIV_LAT];
  logic               degen_q [DIV_LAT];
  logic [Q_W-1:0]     quo [3];
  logic               sat [3];
  logic [Q_W-1:0]     wgt [3];
  logic               done_q, inside_q, degen_out_q;
  logic [Q_W-1:0]     wa_q, wb_q, wc_q;

  for (genvar k = 0; k < 3; k++) begin : g_div
    bpt_div u_div (
      .clk_i,
      .num_i(item_i.num_mag[k]),
      .den_i(item_i.den_mag),
      .quo_o(quo[k]),
      .sat_o(sat[k])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wgt[k] = degen_q[DIV_LAT-1] ? '0 :
               fix_weight(quo[k], sat[k], neg_q[DIV_LAT-1][k], thr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DIV_LAT-2:0], valid_i};
      done_q <= vld_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0]   <= item_i.num_neg;
    degen_q[0] <= item_i.degen;
    for (int s = 1; s < DIV_LAT; s++) begin
      neg_q[s]   <= neg_q[s-1];
      degen_q[s] <= degen_q[s-1];
    end
    wa_q        <= wgt[0];
    wb_q        <= wgt[1];
    wc_q        <= wgt[2];
    inside_q    <= !degen_q[DIV_LAT-1] && !wgt[0][Q_W-1] && !wgt[1][Q_W-1] && !wgt[2][Q_W-1];
    degen_out_q <= degen_q[DIV_LAT-1];
  end

  assign done_o       = done_q;
  assign weight_a_o   = wa_q;
  assign weight_b_o   = wb_q;
  assign weight_c_o   = wc_q;
  assign inside_res_o = inside_q;
  assign degenerate_o = degen_out_q;

endmodule

@@ hdl/barycentric_point_in_triangle_top.sv @@
// Result path: an accepted request is registered at capture, then passes the 5 determinant
// stages, the queue, the 33 divider stages and the output register before done_o rises.
// Throughput: one request per cycle; the divider pipelines retire one result a cycle.
// The two-entry queue drains every cycle, so busy stays low in operation.
// Reset (asynchronous, active low) empties the pipeline and the queue and clears the
// threshold register to zero.
module barycentric_point_in_triangle_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] vert_a_x_i,
  input  logic [31:0] vert_a_y_i,
  input  logic [31:0] vert_a_z_i,
  input  logic [31:0] vert_b_x_i,
  input  logic [31:0] vert_b_y_i,
  input  logic [31:0] vert_b_z_i,
  input  logic [31:0] vert_c_x_i,
  input  logic [31:0] vert_c_y_i,
  input  logic [31:0] vert_c_z_i,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic [31:0] point_z_i,
  output logic        done_o,
  output logic [31:0] weight_a_o,
  output logic [31:0] weight_b_o,
  output logic [31:0] weight_c_o,
  output logic        inside_res_o,
  output logic        degenerate_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bpt_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic             accept, push, empty, full;
  item_t            wr_item, rd_item;
  vec_t             va, vb, vc, vp;

  assign accept = start && !busy;
  assign busy   = full;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  assign va = '{x: vert_a_x_i, y: vert_a_y_i, z: vert_a_z_i};
  assign vb = '{x: vert_b_x_i, y: vert_b_y_i, z: vert_b_z_i};
  assign vc = '{x: vert_c_x_i, y: vert_c_y_i, z: vert_c_z_i};
  assign vp = '{x: point_x_i, y: point_y_i, z: point_z_i};

  bpt_front u_front (
    .clk_i, .rst_ni, .accept_i(accept),
    .vert_a_i(va), .vert_b_i(vb), .vert_c_i(vc), .point_i(vp),
    .push_o(push), .item_o(wr_item)
  );

  bpt_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wr_item),
    .pop_i(!empty), .rdata_o(rd_item), .empty_o(empty), .full_o(full)
  );

  bpt_back u_back (
    .clk_i, .rst_ni, .thr_i(thr_q), .valid_i(!empty), .item_i(rd_item),
    .done_o, .weight_a_o, .weight_b_o, .weight_c_o, .inside_res_o, .degenerate_o
  );

endmodule

@@ hdl/bpt_checker.sv @@
// Port-level checks for the barycentric point-in-triangle top level, bound in below.
// Depends on bpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] weight_a_o,
  input logic [31:0] weight_b_o,
  input logic [31:0] weight_c_o,
  input logic        inside_res_o,
  input logic        degenerate_o
);
  import bpt_pkg::*;

  logic weights_zero, weights_nonneg;

  assign weights_zero   = (weight_a_o == '0) && (weight_b_o == '0) && (weight_c_o == '0);
  assign weights_nonneg = !weight_a_o[31] && !weight_b_o[31] && !weight_c_o[31];

  `ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, done_o && degenerate_o, weights_zero && !inside_res_o)
  `ASSERT_IMPL(a_inside_sign, clk_i, rst_ni, done_o && inside_res_o, weights_nonneg)
  `ASSERT_IMPL(a_latency, clk_i, rst_ni, done_o, $past(start && !busy, RESULT_LAT))
  `ASSERT_NEVER(a_no_backup, clk_i, rst_ni, busy)

endmodule

bind barycentric_point_in_triangle_top bpt_checker u_chk (.*);
